// ===== hw/rtl/sstf_pkg.sv =====
// Shared constants and types for the shortest-seek-first scheduler.
// No dependencies; compiled first.
`default_nettype none

package sstf_pkg;

    localparam int CYL_W           = 16;
    localparam int SUM_W           = 22;
    localparam int MAX_REQUESTS_DEF = 8;

    // Best candidate handed from cell to cell during a sweep
    typedef struct packed {
        logic             found;
        logic [CYL_W-1:0] gap;
        logic [CYL_W-1:0] cyl;
    } t_cand;

endpackage

`default_nettype wire

// ===== hw/rtl/sstf_req_if.sv =====
// Request channel: valid/ready handshake with one cylinder request.
// Depends on sstf_pkg.
`default_nettype none

interface sstf_req_if;
    import sstf_pkg::*;

    logic             valid;
    logic             ready;
    logic [CYL_W-1:0] request_cylinder;
    logic             last_request;

    modport source (output valid, output request_cylinder, output last_request,
                    input ready);
    modport sink   (input valid, input request_cylinder, input last_request,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sstf_res_if.sv =====
// Result channel: valid/ready handshake with one served request.
// Depends on sstf_pkg.
`default_nettype none

interface sstf_res_if;
    import sstf_pkg::*;

    logic             valid;
    logic             ready;
    logic [CYL_W-1:0] served_cylinder;
    logic [CYL_W-1:0] seek_distance;
    logic [SUM_W-1:0] total_movement;
    logic             overflow;
    logic             last_result;

    modport source (output valid, output served_cylinder, output seek_distance,
                    output total_movement, output overflow, output last_result,
                    input ready);
    modport sink   (input valid, input served_cylinder, input seek_distance,
                    input total_movement, input overflow, input last_result,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sstf_cell.sv =====
// One store slot of the scheduler chain: holds a cylinder and merges it
// into the registered best candidate passed on to the next cell.
// Depends on sstf_pkg.
`default_nettype none

module sstf_cell #(
    parameter int IDX_W    = 3,
    parameter int CELL_IDX = 0
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_wr_en,
    input  wire logic [sstf_pkg::CYL_W-1:0] i_wr_data,
    input  wire logic                     i_active,
    input  wire logic [sstf_pkg::CYL_W-1:0] i_head,
    input  wire sstf_pkg::t_cand          i_cand,
    input  wire logic [IDX_W-1:0]         i_cand_idx,
    output sstf_pkg::t_cand               o_cand,
    output logic [IDX_W-1:0]              o_cand_idx,
    output logic [sstf_pkg::CYL_W-1:0]    o_cyl
);
    import sstf_pkg::*;

    logic [CYL_W-1:0] r_cyl;
    t_cand            r_cand;
    t_cand            n_cand;
    logic [IDX_W-1:0] r_cand_idx;
    logic [IDX_W-1:0] n_cand_idx;
    logic [CYL_W-1:0] w_gap;
    logic             w_take;

    assign w_gap  = (r_cyl >= i_head) ? (r_cyl - i_head) : (i_head - r_cyl);
    // strict compare keeps the lower index on a tie
    assign w_take = i_active && (!i_cand.found || (w_gap < i_cand.gap));

    always_comb begin
        if (w_take) begin
            n_cand.found = 1'b1;
            n_cand.gap   = w_gap;
            n_cand.cyl   = r_cyl;
            n_cand_idx   = IDX_W'(CELL_IDX);
        end else begin
            n_cand     = i_cand;
            n_cand_idx = i_cand_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_cyl <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.found <= 1'b0;
        end else begin
            r_cand.found <= n_cand.found;
        end
        r_cand.gap <= n_cand.gap;
        r_cand.cyl <= n_cand.cyl;
        r_cand_idx <= n_cand_idx;
    end

    assign o_cand     = r_cand;
    assign o_cand_idx = r_cand_idx;
    assign o_cyl      = r_cyl;

endmodule

`default_nettype wire

// ===== hw/rtl/sstf_seek_scheduler_core.sv =====
// Shortest-seek-first scheduler: loads a batch of cylinder requests into a
// chain of cells and serves them nearest-first from a start head position.
//
// Usage:
//   i_req  carries one request per handshake; last_request closes the batch.
//          Ready is high while loading and low while the batch is served.
//          Requests beyond MAX_REQUESTS are dropped and flag overflow.
//   o_res  carries one result per served request, last_result on the final.
//   i_cfg_we / i_cfg_wdata write start_head; write it only while idle.
// Timing:
//   Loading accepts one request per cycle. Each pick sweeps a candidate
//   through the MAX_REQUESTS registered cells, and a result is registered
//   once the sweep has crossed the last cell and the output register is free.
// Reset clears the counters, sums and channels; store contents stay as is.
// When the receiver stalls, the finished result sits in the output
// register and the next pick waits for it to be taken.
`default_nettype none

module sstf_seek_scheduler_core #(
    parameter int MAX_REQUESTS = sstf_pkg::MAX_REQUESTS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [sstf_pkg::CYL_W-1:0] i_cfg_wdata,
    sstf_req_if.sink                        i_req,
    sstf_res_if.source                      o_res
);
    import sstf_pkg::*;

    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_PICK = 1'b1;

    logic             r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_sweep;
    logic [CYL_W-1:0] r_start_head;
    logic [CYL_W-1:0] r_head;
    logic [SUM_W-1:0] r_sum;
    logic             r_drop;

    logic             r_out_valid;
    logic [CYL_W-1:0] r_out_cyl;
    logic [CYL_W-1:0] r_out_gap;
    logic [SUM_W-1:0] r_out_sum;
    logic             r_out_ovf;
    logic             r_out_last;

    t_cand            w_cand     [MAX_REQUESTS+1];
    logic [IDX_W-1:0] w_cand_idx [MAX_REQUESTS+1];
    logic [CYL_W-1:0] w_cell_cyl [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] w_wr_en;
    logic [CYL_W-1:0] w_wr_data;
    logic [IDX_W-1:0] w_last_idx;
    logic [IDX_W-1:0] w_load_idx;
    logic             w_accept;
    logic             w_room;
    logic             w_pick;
    logic [SUM_W-1:0] w_new_sum;
    t_cand            w_best;

    assign i_req.ready = (r_state == ST_LOAD);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_room      = (r_count < CNT_W'(MAX_REQUESTS));
    assign w_last_idx  = IDX_W'(r_count - 1'b1);
    assign w_load_idx  = IDX_W'(r_count);
    assign w_best      = w_cand[MAX_REQUESTS];
    // pick once the candidate has crossed every cell and the output is free
    assign w_pick      = (r_state == ST_PICK) && (r_sweep == CNT_W'(MAX_REQUESTS))
                         && (!r_out_valid || o_res.ready);
    assign w_new_sum   = r_sum + SUM_W'(w_best.gap);

    assign w_cand[0].found = 1'b0;
    assign w_cand[0].gap   = '0;
    assign w_cand[0].cyl   = '0;
    assign w_cand_idx[0]   = '0;

    assign w_wr_data = (r_state == ST_LOAD) ? i_req.request_cylinder
                                            : w_cell_cyl[w_last_idx];

    always_comb begin
        w_wr_en = '0;
        if (w_accept && w_room) begin
            w_wr_en[w_load_idx] = 1'b1;
        end else if (w_pick) begin
            // refill the served slot with the last stored entry
            w_wr_en[w_cand_idx[MAX_REQUESTS]] = 1'b1;
        end
    end

    for (genvar k = 0; k < MAX_REQUESTS; k++) begin : g_cell
        sstf_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (w_wr_en[k]),
            .i_wr_data  (w_wr_data),
            .i_active   (CNT_W'(k) < r_count),
            .i_head     (r_head),
            .i_cand     (w_cand[k]),
            .i_cand_idx (w_cand_idx[k]),
            .o_cand     (w_cand[k+1]),
            .o_cand_idx (w_cand_idx[k+1]),
            .o_cyl      (w_cell_cyl[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_head <= '0;
        end else if (i_cfg_we) begin
            r_start_head <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_sweep <= '0;
            r_head  <= '0;
            r_sum   <= '0;
            r_drop  <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_req.last_request) begin
                            r_state <= ST_PICK;
                            r_head  <= r_start_head;
                            r_sweep <= '0;
                        end
                    end
                end
                ST_PICK: begin
                    if (w_pick) begin
                        r_head  <= w_best.cyl;
                        r_count <= r_count - 1'b1;
                        r_sweep <= '0;
                        if (r_count == CNT_W'(1)) begin
                            r_state <= ST_LOAD;
                            r_sum   <= '0;
                            r_drop  <= 1'b0;
                        end else begin
                            r_sum <= w_new_sum;
                        end
                    end else if (r_sweep != CNT_W'(MAX_REQUESTS)) begin
                        r_sweep <= r_sweep + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pick) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_pick) begin
            r_out_cyl  <= w_best.cyl;
            r_out_gap  <= w_best.gap;
            r_out_sum  <= w_new_sum;
            r_out_ovf  <= r_drop;
            r_out_last <= (r_count == CNT_W'(1));
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.served_cylinder = r_out_cyl;
    assign o_res.seek_distance   = r_out_gap;
    assign o_res.total_movement  = r_out_sum;
    assign o_res.overflow        = r_out_ovf;
    assign o_res.last_result     = r_out_last;

endmodule

`default_nettype wire
